// File: design/bu2x_pkg.sv
// ---------------------------------------------------------------------------
// bu2x_pkg: shared types, constants and arithmetic for the 2x bilinear upscaler
// Field widths, register indexes, default frame limits and the lerp helper.
// ---------------------------------------------------------------------------
package bu2x_pkg;

   localparam int PIX_W          = 8;
   localparam int COORD_W        = 12;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Blocks that one source pixel completes, in emission order up_left first.
   typedef struct packed {
      logic cur_edge;
      logic cur_left;
      logic up_edge;
      logic up_left;
   } blk_set_type;

   // (3a + b + 2) >> 2, never exceeds 10 bits before the shift
   function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      logic [PIX_W+1:0] s;
      s = {1'b0, a, 1'b0} + {2'b00, a} + {2'b00, b} + (PIX_W+2)'(2);
      return s[PIX_W+1:2];
   endfunction

endpackage

// File: design/bu2x_cfg.sv
// ---------------------------------------------------------------------------
// bu2x_cfg: frame size registers
// Hold the clamped last column and last row index of the source frame.
// ---------------------------------------------------------------------------
module bu2x_cfg #(
   parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bu2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bu2x_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bu2x_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] col_last,
   output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row_last
);
   import bu2x_pkg::*;

   localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WC_W  = (CSR_DATA_W > COL_W + 1) ? CSR_DATA_W : COL_W + 1;
   localparam int HC_W  = (CSR_DATA_W > ROW_W + 1) ? CSR_DATA_W : ROW_W + 1;

   logic [COL_W-1:0] col_last_ff, col_last_in, col_clamped;
   logic [ROW_W-1:0] row_last_ff, row_last_in, row_clamped;
   logic [WC_W-1:0]  wval;
   logic [HC_W-1:0]  hval;

   // zero counts as one, anything above the maximum saturates
   always_comb begin
      wval = WC_W'(csr_wdata);
      hval = HC_W'(csr_wdata);
      if (wval == '0) begin
         col_clamped = '0;
      end else if (wval > WC_W'(MAX_WIDTH)) begin
         col_clamped = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_clamped = COL_W'(wval - WC_W'(1));
      end
      if (hval == '0) begin
         row_clamped = '0;
      end else if (hval > HC_W'(MAX_HEIGHT)) begin
         row_clamped = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_clamped = ROW_W'(hval - HC_W'(1));
      end
   end

   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  col_last_in = col_clamped;
            CSR_IMAGE_HEIGHT: row_last_in = row_clamped;
            default: begin
               col_last_in = col_last_ff;
               row_last_in = row_last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= '0;
         row_last_ff <= '0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
      end
   end

   assign col_last = col_last_ff;
   assign row_last = row_last_ff;

endmodule

// File: design/bu2x_front.sv
// ---------------------------------------------------------------------------
// bu2x_front: input stage with raster position and line store
// Accept pixels, track column/row, keep the previous row, load the work stage.
// ---------------------------------------------------------------------------
module bu2x_front #(
   parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bu2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bu2x_pkg::PIX_W-1:0]          req_pixel,
   input  logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] col_last,
   input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row_last,
   input  logic                                retire,
   output logic                                load,
   output bu2x_pkg::blk_set_type               blk_set,
   output logic                                s1_valid,
   output logic [bu2x_pkg::PIX_W-1:0]          s1_pixel,
   output logic [bu2x_pkg::PIX_W-1:0]          s1_above,
   output logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] s1_col,
   output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row
);
   import bu2x_pkg::*;

   localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [PIX_W-1:0] line_mem [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in, s1_col_ff;
   logic [ROW_W-1:0] row_ff, row_in, s1_row_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pixel_ff, s1_above_ff;
   logic             accept, last_col, last_row;

   assign req_ready = !s1_valid_ff || retire;
   assign accept    = req_valid && req_ready;
   assign last_col  = col_ff >= col_last;
   assign last_row  = row_ff >= row_last;

   always_comb begin
      blk_set.up_left  = (row_ff != '0) && (col_ff != '0);
      blk_set.up_edge  = (row_ff != '0) && last_col;
      blk_set.cur_left = last_row && (col_ff != '0);
      blk_set.cur_edge = last_row && last_col;
   end

   // advance the raster position, wrap at the end of a row and of the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (retire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // read-first line store: the old entry is the pixel above this one
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= req_pixel;
         s1_above_ff      <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   assign load     = accept;
   assign s1_valid = s1_valid_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_above = s1_above_ff;
   assign s1_col   = s1_col_ff;
   assign s1_row   = s1_row_ff;

endmodule

// File: design/bu2x_emit.sv
// ---------------------------------------------------------------------------
// bu2x_emit: block sequencer, interpolation and result register
// Walk the blocks a pixel completes into the output register, one per cycle while it is free.
// ---------------------------------------------------------------------------
module bu2x_emit #(
   parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bu2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  bu2x_pkg::blk_set_type               blk_set,
   input  logic                                s1_valid,
   input  logic [bu2x_pkg::PIX_W-1:0]          s1_pixel,
   input  logic [bu2x_pkg::PIX_W-1:0]          s1_above,
   input  logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] s1_col,
   input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row,
   output logic                                retire,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bu2x_pkg::COORD_W-1:0]        rsp_block_x,
   output logic [bu2x_pkg::COORD_W-1:0]        rsp_block_y,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_left,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_right,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_left,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_right,
   output logic                                rsp_last_of_run
);
   import bu2x_pkg::*;

   localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [3:0] BLK_UP_LEFT  = 4'b0001;
   localparam logic [3:0] BLK_UP_EDGE  = 4'b0010;
   localparam logic [3:0] BLK_CUR_LEFT = 4'b0100;
   localparam logic [3:0] BLK_CUR_EDGE = 4'b1000;

   logic [3:0]       pending_ff, pending_in, sel;
   logic [PIX_W-1:0] left_cur_ff, left_above_ff;
   logic             out_free, send, last_blk, single;
   logic [PIX_W-1:0] tl, tr, bl, br, vl, vr;
   logic [COL_W-1:0] bx;
   logic [ROW_W-1:0] by;
   logic [COL_W+COORD_W-1:0] bx_ext;
   logic [ROW_W+COORD_W-1:0] by_ext;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [PIX_W-1:0] otl_ff, otr_ff, obl_ff, obr_ff;
   logic             last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sel      = pending_ff & (~pending_ff + 4'd1);
   assign last_blk = (pending_ff & ~sel) == 4'd0;
   assign single   = (pending_ff != 4'd0) && last_blk;
   assign send     = s1_valid && (pending_ff != 4'd0) && out_free;
   // a pixel with no block leaves at once; otherwise with its final block
   assign retire   = s1_valid && ((pending_ff == 4'd0) || (single && out_free));

   always_comb begin
      pending_in = pending_ff;
      if (load) begin
         pending_in = {blk_set.cur_edge, blk_set.cur_left,
                       blk_set.up_edge, blk_set.up_left};
      end else if (send) begin
         pending_in = pending_ff & ~sel;
      end
   end

   always_comb begin
      tl = s1_pixel;
      tr = s1_pixel;
      bl = s1_pixel;
      br = s1_pixel;
      bx = s1_col;
      by = s1_row;
      case (sel)
         BLK_UP_LEFT: begin
            tl = left_above_ff;
            tr = s1_above;
            bl = left_cur_ff;
            br = s1_pixel;
            bx = s1_col - COL_W'(1);
            by = s1_row - ROW_W'(1);
         end
         BLK_UP_EDGE: begin
            tl = s1_above;
            tr = s1_above;
            by = s1_row - ROW_W'(1);
         end
         BLK_CUR_LEFT: begin
            tl = left_cur_ff;
            bl = left_cur_ff;
            bx = s1_col - COL_W'(1);
         end
         BLK_CUR_EDGE: begin
            tl = s1_pixel;
         end
         default: begin
            tl = s1_pixel;
         end
      endcase
   end

   assign vl     = lerp(tl, bl);
   assign vr     = lerp(tr, br);
   assign bx_ext = {{COORD_W{1'b0}}, bx};
   assign by_ext = {{COORD_W{1'b0}}, by};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         left_cur_ff   <= '0;
         left_above_ff <= '0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (retire) begin
            left_cur_ff   <= s1_pixel;
            left_above_ff <= s1_above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         x_ff    <= bx_ext[COORD_W-1:0];
         y_ff    <= by_ext[COORD_W-1:0];
         otl_ff  <= lerp(tl, tr);
         otr_ff  <= lerp(tr, tl);
         obl_ff  <= lerp(vl, vr);
         obr_ff  <= lerp(vr, vl);
         last_ff <= last_blk;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_block_x          = x_ff;
   assign rsp_block_y          = y_ff;
   assign rsp_out_top_left     = otl_ff;
   assign rsp_out_top_right    = otr_ff;
   assign rsp_out_bottom_left  = obl_ff;
   assign rsp_out_bottom_right = obr_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

// File: design/bilinear_upscale_2x_u8.sv
// ---------------------------------------------------------------------------
// bilinear_upscale_2x_u8: streaming 2x bilinear upscaler for 8-bit pixels
// Source pixels in raster order in, 2x2 output blocks with position out.
// ---------------------------------------------------------------------------
//
//   channel  | direction | transfer when           | carries
//   ---------+-----------+-------------------------+------------------------------
//   req_     | in        | req_valid & req_ready   | one source pixel
//   rsp_     | out       | rsp_valid & rsp_ready   | one 2x2 block, x/y, last flag
//   csr_     | in        | csr_wr_en               | image_width / image_height
//
// A pixel stays in the work stage until its final block is sent, or leaves at
// once if it completes none (0 to 4 blocks); interior pixels complete one, so
// one pixel per cycle is sustained while rsp_ is not stalled, with longer stays
// only at row ends and on the last row, where the result register drains one
// block per cycle unless stalled. The first block of a pixel goes through the
// work stage register, then the result register. Reset clears position, sizes
// (1x1) and handshakes; the line store is not cleared, the first row fills it.
// A stall on rsp_ backs up into req_ready through the single work stage.
//
module bilinear_upscale_2x_u8 #(
   parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bu2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   // source pixels
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bu2x_pkg::PIX_W-1:0]          req_pixel,
   // output blocks
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bu2x_pkg::COORD_W-1:0]        rsp_block_x,
   output logic [bu2x_pkg::COORD_W-1:0]        rsp_block_y,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_left,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_right,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_left,
   output logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_right,
   output logic                                rsp_last_of_run,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [bu2x_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bu2x_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bu2x_pkg::*;

   localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // frame limits as last index, already clamped
   logic [COL_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;

   // work stage contents handed from the front end to the sequencer
   logic             load, retire, s1_valid;
   blk_set_type      blk_set;
   logic [PIX_W-1:0] s1_pixel, s1_above;
   logic [COL_W-1:0] s1_col;
   logic [ROW_W-1:0] s1_row;

   // size registers; to be written only while the block is idle, which the block itself does not enforce
   bu2x_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .col_last  (col_last),
      .row_last  (row_last)
   );

   // position counters, line store and work stage register
   bu2x_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .col_last  (col_last),
      .row_last  (row_last),
      .retire    (retire),
      .load      (load),
      .blk_set   (blk_set),
      .s1_valid  (s1_valid),
      .s1_pixel  (s1_pixel),
      .s1_above  (s1_above),
      .s1_col    (s1_col),
      .s1_row    (s1_row)
   );

   // pick the next block, interpolate, hold it in the result register
   bu2x_emit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_emit (
      .clock                (clock),
      .reset                (reset),
      .load                 (load),
      .blk_set              (blk_set),
      .s1_valid             (s1_valid),
      .s1_pixel             (s1_pixel),
      .s1_above             (s1_above),
      .s1_col               (s1_col),
      .s1_row               (s1_row),
      .retire               (retire),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_x          (rsp_block_x),
      .rsp_block_y          (rsp_block_y),
      .rsp_out_top_left     (rsp_out_top_left),
      .rsp_out_top_right    (rsp_out_top_right),
      .rsp_out_bottom_left  (rsp_out_bottom_left),
      .rsp_out_bottom_right (rsp_out_bottom_right),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// File: design/bu2x_checker.sv
// ---------------------------------------------------------------------------
// bu2x_checker: port-level checks for the upscaler
// Watch the result channel over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module bu2x_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bu2x_pkg::COORD_W-1:0]        rsp_block_x,
   input logic [bu2x_pkg::COORD_W-1:0]        rsp_block_y,
   input logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_left,
   input logic [bu2x_pkg::PIX_W-1:0]          rsp_out_top_right,
   input logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_left,
   input logic [bu2x_pkg::PIX_W-1:0]          rsp_out_bottom_right,
   input logic                                rsp_last_of_run
);
   import bu2x_pkg::*;

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled block holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_x) &&
         $stable(rsp_block_y) && $stable(rsp_out_top_left) &&
         $stable(rsp_out_top_right) && $stable(rsp_out_bottom_left) &&
         $stable(rsp_out_bottom_right) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // blocks of one pixel follow without a gap
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run of blocks");

   // within a run the block row stays or steps down by one
   a_run_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_last_of_run |=>
         (rsp_block_y == $past(rsp_block_y)) ||
         (rsp_block_y == $past(rsp_block_y) + COORD_W'(1)))
      else $error("block row jumps inside a run");

endmodule

bind bilinear_upscale_2x_u8 bu2x_checker u_checker (.*);
